// File: hdl/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg
// Shared types and constants for the motor current guard.
// ----------------------------------------------------------------------------
package mcg_pkg;

    localparam int BLANK_TICKS_DEF      = 10;
    localparam int LIMIT_CONFIRM_DEF    = 8;
    localparam int BASELINE_SAMPLES_DEF = 5;
    localparam int STALL_CONFIRM_DEF    = 6;

    localparam logic [2:0] CMD_SAMPLE  = 3'd0;
    localparam logic [2:0] CMD_TICK    = 3'd1;
    localparam logic [2:0] CMD_FORWARD = 3'd2;
    localparam logic [2:0] CMD_REVERSE = 3'd3;
    localparam logic [2:0] CMD_STOP    = 3'd4;
    localparam logic [2:0] CMD_LOAD    = 3'd5;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_FWD  = 2'd1;
    localparam logic [1:0] MODE_REV  = 2'd2;

    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_LIMIT = 2'd1;
    localparam logic [1:0] CAUSE_STALL = 2'd2;
    localparam logic [1:0] CAUSE_TRAVEL = 2'd3;

    localparam logic [2:0] REG_GAIN   = 3'd0;
    localparam logic [2:0] REG_OFFSET = 3'd1;
    localparam logic [2:0] REG_ZERO   = 3'd2;
    localparam logic [2:0] REG_RATIO  = 3'd3;
    localparam logic [2:0] REG_DELTA  = 3'd4;

    localparam logic [15:0] FILT_OLD = 16'd58982;
    localparam logic [15:0] FILT_NEW = 16'd6554;

    typedef struct packed {
        logic load;
        logic mul_scale;
        logic mul_trip;
        logic mul_filt;
    } mcg_cmd_t;

endpackage

// File: hdl/mcg_datapath.sv
// ----------------------------------------------------------------------------
// mcg_datapath
// Multiplier datapath: scaling, trip product, baseline divide and filter
// products.
// ----------------------------------------------------------------------------
module mcg_datapath
    import mcg_pkg::*;
#(
    parameter int BASELINE_SAMPLES = BASELINE_SAMPLES_DEF
)
(
    input  logic                clk,
    input  mcg_cmd_t            cmd,
    input  logic [11:0]         adc_sample,
    input  logic [23:0]         current_gain,
    input  logic signed [31:0]  current_offset,
    input  logic [17:0]         stall_ratio,
    input  logic signed [35:0]  baseline,
    output logic signed [31:0]  cur,
    output logic signed [35:0]  trip_mult,
    output logic signed [35:0]  filt_value,
    output logic signed [35:0]  base_quot
);

    localparam logic [37:0] BASE_RECIP =
        38'(((64'd1 << 37) + 64'(BASELINE_SAMPLES) - 64'd1) / 64'(BASELINE_SAMPLES));

    logic [35:0]         prod_reg;
    logic signed [31:0]  cur_reg;
    logic signed [35:0]  trip_reg;
    logic signed [52:0]  fold_reg;
    logic signed [35:0]  filt_reg;
    logic [53:0]         dlo_reg;
    logic signed [35:0]  quot_reg;
    logic signed [33:0]  sum;
    logic signed [53:0]  tprod;
    logic signed [52:0]  fnew;
    logic signed [53:0]  fsum;
    logic signed [35:0]  bsum;
    logic                bneg;
    logic [34:0]         bmag;
    logic [53:0]         dhi;
    logic [72:0]         dsum;
    logic [34:0]         dq;

    always_comb
    begin
        sum = $signed({6'd0, prod_reg[35:8]}) + $signed({2'd0, prod_reg[7]})
              + 34'(current_offset);
        tprod = 54'(baseline) * $signed({36'd0, stall_ratio});
        fnew = 53'(cur) * $signed({37'd0, FILT_NEW});
        fsum = 54'(fold_reg) + 54'(fnew) + 54'sd32768;
        bsum = baseline + 36'(cur);
        bneg = bsum[35];
        bmag = bneg ? 35'(-bsum) : bsum[34:0];
        dhi = 54'(bmag) * 54'(BASE_RECIP[37:19]);
        dsum = 73'(dlo_reg) + {dhi, 19'd0};
        dq = dsum[71:37];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prod_reg <= 36'(adc_sample) * 36'(current_gain);
            fold_reg <= 53'(baseline) * $signed({37'd0, FILT_OLD});
        end
        if (cmd.mul_scale)
        begin
            if (sum > 34'sd2147483647)
                cur_reg <= 32'sh7fffffff;
            else if (sum < -34'sd2147483648)
                cur_reg <= 32'sh80000000;
            else
                cur_reg <= sum[31:0];
        end
        if (cmd.mul_trip)
        begin
            trip_reg <= tprod[51:16];
            dlo_reg <= 54'(bmag) * 54'(BASE_RECIP[18:0]);
        end
        if (cmd.mul_filt)
        begin
            filt_reg <= fsum[51:16];
            quot_reg <= bneg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
        end
    end

    assign cur        = cur_reg;
    assign trip_mult  = trip_reg;
    assign filt_value = filt_reg;
    assign base_quot  = quot_reg;

endmodule

// File: hdl/mcg_control.sv
// ----------------------------------------------------------------------------
// mcg_control
// Sequencer and guard state: run mode, counters, baseline, travel.
// ----------------------------------------------------------------------------
module mcg_control
    import mcg_pkg::*;
#(
    parameter int BLANK_TICKS      = BLANK_TICKS_DEF,
    parameter int LIMIT_CONFIRM    = LIMIT_CONFIRM_DEF,
    parameter int BASELINE_SAMPLES = BASELINE_SAMPLES_DEF,
    parameter int STALL_CONFIRM    = STALL_CONFIRM_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         command,
    input  logic signed [31:0] travel_value,
    input  logic               homing,
    input  logic               calibrating,
    input  logic               stall_inhibit,
    input  logic signed [31:0] low_limit,
    input  logic [30:0]        stall_delta,
    output mcg_cmd_t           cmd,
    output logic signed [35:0] baseline,
    input  logic signed [31:0] cur,
    input  logic signed [35:0] trip_mult,
    input  logic signed [35:0] filt_value,
    input  logic signed [35:0] base_quot,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         mode,
    output logic signed [31:0] last_current,
    output logic signed [31:0] travel,
    output logic [1:0]         cause
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_TRIP  = 3'd2;
    localparam logic [2:0] S_FILT  = 3'd3;
    localparam logic [2:0] S_EXEC  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [2:0]         cmd_reg;
    logic               hs_reg, cal_reg, ign_reg;
    logic signed [31:0] travel_value_reg;
    logic [1:0]         mode_reg, mode_next;
    logic signed [31:0] last_reg, last_next;
    logic [3:0]         blank_reg, blank_next;
    logic [3:0]         low_reg, low_next;
    logic [2:0]         stall_reg, stall_next;
    logic [2:0]         bcnt_reg, bcnt_next;
    logic signed [35:0] base_reg, base_next;
    logic               bready_reg, bready_next;
    logic signed [31:0] travel_reg, travel_next;
    logic [1:0]         cause_reg, cause_next;
    logic               ovalid_reg, ovalid_next;
    logic [3:0]         blank_dec;
    logic signed [35:0] alt, trip;
    logic               running;

    assign in_ready = (state_reg == S_IDLE) && (!ovalid_reg || out_ready);
    assign cmd.load      = in_valid && in_ready;
    assign cmd.mul_scale = (state_reg == S_SCALE);
    assign cmd.mul_trip  = (state_reg == S_TRIP);
    assign cmd.mul_filt  = (state_reg == S_FILT);
    assign baseline = base_reg;

    always_comb
    begin
        running = (mode_reg == MODE_FWD) || (mode_reg == MODE_REV);
        blank_dec = (blank_reg != 4'd0) ? blank_reg - 4'd1 : blank_reg;
        alt = base_reg + 36'(stall_delta);
        trip = (trip_mult < alt) ? alt : trip_mult;
        state_next = state_reg;
        mode_next = mode_reg;
        last_next = last_reg;
        blank_next = blank_reg;
        low_next = low_reg;
        stall_next = stall_reg;
        bcnt_next = bcnt_reg;
        base_next = base_reg;
        bready_next = bready_reg;
        travel_next = travel_reg;
        cause_next = cause_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_SCALE;
                    if (stall_inhibit)
                        stall_next = 3'd0;
                end
            end
            S_SCALE: state_next = S_TRIP;
            S_TRIP:  state_next = S_FILT;
            S_FILT:  state_next = S_EXEC;
            S_EXEC:
            begin
                state_next = S_IDLE;
                ovalid_next = 1'b1;
                cause_next = CAUSE_NONE;
                case (cmd_reg)
                    CMD_SAMPLE:
                    begin
                        blank_next = blank_dec;
                        last_next = cur;
                        if (mode_reg == MODE_REV && travel_reg <= 0 && !hs_reg && !cal_reg)
                        begin
                            travel_next = '0;
                            cause_next = CAUSE_TRAVEL;
                        end
                        else if (cur < low_limit)
                        begin
                            if (hs_reg || ign_reg || blank_dec != 4'd0)
                                low_next = 4'd0;
                            else if (low_reg < 4'(LIMIT_CONFIRM))
                                low_next = low_reg + 4'd1;
                            else
                            begin
                                low_next = 4'd0;
                                if (running)
                                    cause_next = CAUSE_LIMIT;
                            end
                        end
                        else
                        begin
                            low_next = 4'd0;
                            if (hs_reg || cal_reg || ign_reg || blank_dec != 4'd0)
                                stall_next = 3'd0;
                            else if (running)
                            begin
                                if (!bready_reg)
                                begin
                                    base_next = base_reg + 36'(cur);
                                    bcnt_next = bcnt_reg + 3'd1;
                                    if (bcnt_next >= 3'(BASELINE_SAMPLES))
                                    begin
                                        base_next = base_quot;
                                        bready_next = 1'b1;
                                        stall_next = 3'd0;
                                    end
                                end
                                else if (cur >= trip)
                                begin
                                    stall_next = stall_reg + 3'd1;
                                    if (stall_next >= 3'(STALL_CONFIRM))
                                        cause_next = CAUSE_STALL;
                                end
                                else
                                begin
                                    stall_next = 3'd0;
                                    if (36'(cur) < base_reg)
                                        base_next = filt_value;
                                end
                            end
                        end
                    end
                    CMD_TICK:
                    begin
                        if (cal_reg)
                        begin
                            if (running)
                                travel_next = travel_reg + 32'sd1;
                        end
                        else if (mode_reg == MODE_FWD)
                            travel_next = travel_reg + 32'sd1;
                        else if (mode_reg == MODE_REV)
                        begin
                            travel_next = (travel_reg > 0) ? travel_reg - 32'sd1 : travel_reg;
                            if (travel_next <= 0 && !hs_reg)
                            begin
                                travel_next = '0;
                                cause_next = CAUSE_TRAVEL;
                            end
                        end
                    end
                    CMD_FORWARD, CMD_REVERSE, CMD_STOP:
                    begin
                        mode_next = (cmd_reg == CMD_FORWARD) ? MODE_FWD :
                                    (cmd_reg == CMD_REVERSE) ? MODE_REV : MODE_IDLE;
                        if (cmd_reg != CMD_STOP)
                            blank_next = 4'(BLANK_TICKS);
                        low_next = '0; stall_next = '0; bcnt_next = '0;
                        base_next = '0; bready_next = 1'b0;
                    end
                    CMD_LOAD: travel_next = travel_value_reg;
                    default: ;
                endcase
                if (cause_next != CAUSE_NONE)
                begin
                    mode_next = MODE_IDLE;
                    low_next = '0; stall_next = '0; bcnt_next = '0;
                    base_next = '0; bready_next = 1'b0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= command;
            travel_value_reg <= travel_value;
            hs_reg <= homing;
            cal_reg <= calibrating;
            ign_reg <= stall_inhibit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; mode_reg <= MODE_IDLE; last_reg <= '0;
            blank_reg <= '0; low_reg <= '0; stall_reg <= '0; bcnt_reg <= '0;
            base_reg <= '0; bready_reg <= 1'b0; travel_reg <= '0;
            cause_reg <= CAUSE_NONE; ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; mode_reg <= mode_next; last_reg <= last_next;
            blank_reg <= blank_next; low_reg <= low_next; stall_reg <= stall_next;
            bcnt_reg <= bcnt_next; base_reg <= base_next; bready_reg <= bready_next;
            travel_reg <= travel_next; cause_reg <= cause_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign mode = mode_reg;
    assign last_current = last_reg;
    assign travel = travel_reg;
    assign cause = cause_reg;

`ifndef SYNTHESIS
    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && cause_next != CAUSE_NONE) |=> mode_reg == MODE_IDLE)
        else $error("stop did not idle motor");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !in_ready)
        else $error("accepted during work");
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> out_valid)
        else $error("result missing");
`endif

endmodule

// File: hdl/motor_current_guard.sv
// Requests step through scale, trip, filter and update before the result is valid.
// A new request is taken only once the block is back in idle, after the shared
// multiply sequence (scale, trip and divide products, filter product, update);
// a result not yet taken holds off the next request.
// Reset: rst_n clears motor to idle, all counters, baseline and travel to zero,
// and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// motor_current_guard
// DC motor driver with limit, stall and travel-end guarding.
// ----------------------------------------------------------------------------
module motor_current_guard
    import mcg_pkg::*;
#(
    parameter int BLANK_TICKS      = BLANK_TICKS_DEF,
    parameter int LIMIT_CONFIRM    = LIMIT_CONFIRM_DEF,
    parameter int BASELINE_SAMPLES = BASELINE_SAMPLES_DEF,
    parameter int STALL_CONFIRM    = STALL_CONFIRM_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // command[2:0], adc_sample[14:3], travel_value[46:15]
    input  logic [2:0]  s_axis_tuser,   // homing, calibrating, stall_inhibit
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // drive_forward, drive_reverse, motor_status[3:2],
                                        // measured_current[35:4], travel_count[67:36],
                                        // stop_cause[69:68]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [23:0]        gain_reg;
    logic signed [31:0] offset_reg, zero_reg;
    logic [17:0]        ratio_reg;
    logic [30:0]        delta_reg;
    mcg_cmd_t           cmd;
    logic signed [35:0] baseline, trip_mult, filt_value, base_quot;
    logic signed [31:0] cur, last_current, travel;
    logic [1:0]         mode, cause;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0; offset_reg <= '0; zero_reg <= '0;
            ratio_reg <= 18'd78643; delta_reg <= 31'd9830;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN:   gain_reg <= cfg_data[23:0];
                REG_OFFSET: offset_reg <= cfg_data;
                REG_ZERO:   zero_reg <= cfg_data;
                REG_RATIO:  ratio_reg <= cfg_data[17:0];
                REG_DELTA:  delta_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    mcg_datapath #(
        .BASELINE_SAMPLES(BASELINE_SAMPLES)
    ) u_dp (
        .clk(clk), .cmd(cmd), .adc_sample(s_axis_tdata[14:3]),
        .current_gain(gain_reg), .current_offset(offset_reg),
        .stall_ratio(ratio_reg), .baseline(baseline), .cur(cur),
        .trip_mult(trip_mult), .filt_value(filt_value), .base_quot(base_quot)
    );

    mcg_control #(
        .BLANK_TICKS(BLANK_TICKS), .LIMIT_CONFIRM(LIMIT_CONFIRM),
        .BASELINE_SAMPLES(BASELINE_SAMPLES), .STALL_CONFIRM(STALL_CONFIRM)
    ) u_ctl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .command(s_axis_tdata[2:0]), .travel_value(s_axis_tdata[46:15]),
        .homing(s_axis_tuser[0]), .calibrating(s_axis_tuser[1]),
        .stall_inhibit(s_axis_tuser[2]), .low_limit(zero_reg),
        .stall_delta(delta_reg), .cmd(cmd), .baseline(baseline), .cur(cur),
        .trip_mult(trip_mult), .filt_value(filt_value), .base_quot(base_quot),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready), .mode(mode), .last_current(last_current),
        .travel(travel), .cause(cause)
    );

    assign m_axis_tdata = {2'b00, cause, travel, last_current, mode,
                           mode == MODE_REV, mode == MODE_FWD};

endmodule
